### rtl/srlm_pkg.sv
// Shared constants and types of the stereo RMS level meter.
// Used by the channel interfaces and by every module of the meter; depends on nothing.
package srlm_pkg;

   // Buffer length limit and the widths that follow from it.
   localparam int MAX_PAIRS  = 256;
   localparam int COUNT_W    = $clog2(MAX_PAIRS + 1);

   // Fixed field widths.
   localparam int SAMPLE_W   = 16;
   localparam int SQUARE_W   = 31;
   localparam int SUM_W      = 40;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int LEVEL_W    = 15;
   localparam int ACC_W      = 24;
   localparam int ALPHA_W    = 16;
   localparam int SCALED_W   = 16;
   localparam int BAND_W     = 2;

   // The shared divider serves both the mean (divisor 2*count) and the scale (full scale).
   localparam int DIVISOR_W  = ((COUNT_W + 1) > LEVEL_W) ? (COUNT_W + 1) : LEVEL_W;

   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_ALPHA     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE_LEVEL = 1'd1;
   localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RESET     = 16'd4588;
   localparam logic [LEVEL_W-1:0] FULL_SCALE_LEVEL_RESET = 15'd5571;

   // Band thresholds on the Q0.16 scaled level.
   localparam logic [SCALED_W-1:0] BAND_QUARTER  = 16'd16384;
   localparam logic [SCALED_W-1:0] BAND_HALF     = 16'd32768;
   localparam logic [SCALED_W-1:0] BAND_3QUARTER = 16'd49152;
   localparam logic [BAND_W-1:0]   BAND_LOW      = 2'd0;
   localparam logic [BAND_W-1:0]   BAND_LOW_MID  = 2'd1;
   localparam logic [BAND_W-1:0]   BAND_HIGH_MID = 2'd2;
   localparam logic [BAND_W-1:0]   BAND_HIGH     = 2'd3;

   // Request into the shared divider.
   typedef struct packed {
      logic                 start;
      logic [SUM_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

endpackage

### rtl/srlm_if.sv
// Handshake channel interfaces of the stereo RMS level meter.
// Depends on srlm_pkg for the field widths.
interface srlm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [srlm_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [srlm_pkg::SAMPLE_W-1:0] right_sample;
   logic                                last_in_buffer;

   modport source (output valid, left_sample, right_sample, last_in_buffer, input ready);
   modport sink   (input valid, left_sample, right_sample, last_in_buffer, output ready);
endinterface

interface srlm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [srlm_pkg::LEVEL_W-1:0]       rms_level;
   logic [srlm_pkg::LEVEL_W-1:0]       smoothed_level;
   logic [srlm_pkg::SCALED_W-1:0]      scaled_level;
   logic [srlm_pkg::BAND_W-1:0]        level_band;

   modport source (output valid, rms_level, smoothed_level, scaled_level, level_band,
                   input ready);
   modport sink   (input valid, rms_level, smoothed_level, scaled_level, level_band,
                   output ready);
endinterface

### rtl/srlm_lane.sv
// One squaring lane: registers the square of one signed Q1.15 sample.
// Depends on srlm_pkg for widths.
module srlm_lane (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic signed [srlm_pkg::SAMPLE_W-1:0] sample,
   output logic        [srlm_pkg::SQUARE_W-1:0] square
);
   import srlm_pkg::*;

   logic signed [2*SAMPLE_W-1:0] product;
   logic [SQUARE_W-1:0]          square_ff;
   logic [SQUARE_W-1:0]          square_in;

   // The square is never negative and at most 2^30, so the low 31 bits hold it.
   always_comb begin
      product   = sample * sample;
      square_in = load ? product[SQUARE_W-1:0] : square_ff;
   end

   always_ff @(posedge clock) begin
      square_ff <= square_in;
   end

   assign square = square_ff;
endmodule

### rtl/srlm_merge.sv
// Merging stage: adds both lane squares into the saturating sum and counts pairs.
// Depends on srlm_pkg for widths and the buffer length limit.
module srlm_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                add_en,
   input  logic                                clear,
   input  logic [srlm_pkg::SQUARE_W-1:0]       square_left,
   input  logic [srlm_pkg::SQUARE_W-1:0]       square_right,
   output logic [srlm_pkg::SUM_W-1:0]          sum_of_squares,
   output logic [srlm_pkg::COUNT_W-1:0]        sample_count
);
   import srlm_pkg::*;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W:0]     total;

   // Pairs past the limit add nothing; the sum saturates at its maximum.
   always_comb begin
      total    = {1'b0, sum_ff} + (SUM_W + 1)'(square_left) + (SUM_W + 1)'(square_right);
      sum_in   = sum_ff;
      count_in = count_ff;
      if (clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (add_en && (count_ff < COUNT_W'(MAX_PAIRS))) begin
         sum_in   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   assign sum_of_squares = sum_ff;
   assign sample_count   = count_ff;
endmodule

### rtl/srlm_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the mean and the scale.
// Depends on srlm_pkg for widths and the request struct.
module srlm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  srlm_pkg::div_req_type         req,
   output logic [srlm_pkg::SUM_W-1:0]    quotient,
   output logic                          done
);
   import srlm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   // The dividend shifts out of the top of quo_ff while quotient bits shift in below.
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

### rtl/srlm_sqrt.sv
// Integer square root, one result bit per cycle from two radicand bits.
// Depends on srlm_pkg for widths.
module srlm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srlm_pkg::SUM_W-1:0]    radicand,
   output logic [srlm_pkg::ROOT_W-1:0]   root,
   output logic                          done
);
   import srlm_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ROOT_W+2:0]   rem_shift;
   logic [ROOT_W+2:0]   trial;
   logic [ROOT_W+2:0]   diff;
   logic                fits;

   // Classic digit recurrence: try (4*root + 1) against the shifted remainder.
   always_comb begin
      rem_shift = {rem_ff, rad_ff[SUM_W-1:SUM_W-2]};
      trial     = {1'b0, root_ff, 2'b01};
      diff      = rem_shift - trial;
      fits      = (rem_shift >= trial);
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ROOT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[SUM_W-3:0], 2'b00};
         rem_in  = fits ? diff[ROOT_W:0] : rem_shift[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

### rtl/stereo_rms_level_meter_unit.sv
// Top level of the stereo RMS level meter: lanes, merge, shared divider, root and smoothing.
// Depends on srlm_pkg, srlm_if, srlm_lane, srlm_merge, srlm_divider and srlm_sqrt.
//
// Each accepted item is a stereo pair; two lanes square the left and right samples in
// parallel and a merge stage adds both into a saturating 40-bit sum and a pair count
// (pairs past MAX_PAIRS in one buffer are ignored). An ordinary item is accepted in
// S_IDLE and merged in S_MERGE, while the input is not ready. An item marked last in its
// buffer also runs the buffer-end sequence before the next item is accepted: the mean
// goes through the shared one-bit-per-cycle divider, the square root follows, the
// smoothing update uses one multiply and one add, and the full-scale mapping reuses the
// divider. One result item follows each buffer; it sits in an output register, so the
// meter takes new items while it waits to be collected, and holds a later buffer's
// result only until that register is free. smooth_alpha and full_scale_level are to be
// written through the csr port only while the meter is idle; the meter does not enforce it.
module stereo_rms_level_meter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   srlm_req_if.sink                               req_chan,
   srlm_rsp_if.source                             rsp_chan,
   input  logic                                   csr_write,
   input  logic [srlm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [srlm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import srlm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MERGE, S_MEAN, S_MEAN_WAIT, S_ROOT, S_ROOT_WAIT,
      S_MUL, S_ADD, S_SCALE, S_SCALE_WAIT, S_OUT
   } state_type;

   localparam int DIFF_W = ACC_W + 1;
   localparam int PROD_W = ALPHA_W + 1 + DIFF_W;

   state_type                 state_ff, state_in;
   logic                      last_ff, last_in;
   logic                      count_zero_ff, count_zero_in;
   logic [LEVEL_W-1:0]        rms_ff, rms_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [ALPHA_W-1:0]        alpha_ff, alpha_in;
   logic [LEVEL_W-1:0]        full_scale_ff, full_scale_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]        rsp_rms_ff, rsp_rms_in;
   logic [LEVEL_W-1:0]        rsp_smoothed_ff, rsp_smoothed_in;
   logic [SCALED_W-1:0]       rsp_scaled_ff, rsp_scaled_in;
   logic [BAND_W-1:0]         rsp_band_ff, rsp_band_in;

   logic                      accept;
   logic                      merge_clear;
   logic [SQUARE_W-1:0]       square_left;
   logic [SQUARE_W-1:0]       square_right;
   logic [SUM_W-1:0]          sum_of_squares;
   logic [COUNT_W-1:0]        sample_count;
   div_req_type               div_req;
   logic [SUM_W-1:0]          quotient;
   logic                      div_done;
   logic                      sqrt_start;
   logic [SUM_W-1:0]          radicand;
   logic [ROOT_W-1:0]         root;
   logic                      sqrt_done;
   logic [LEVEL_W-1:0]        fs_eff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  acc_sum;
   logic [ACC_W:0]            smoothed_round;
   logic [SCALED_W-1:0]       scaled;
   logic [BAND_W-1:0]         band;

   // Squaring lanes, one per channel.
   srlm_lane u_lane_left (
      .clock  (clock),
      .load   (accept),
      .sample (req_chan.left_sample),
      .square (square_left)
   );

   srlm_lane u_lane_right (
      .clock  (clock),
      .load   (accept),
      .sample (req_chan.right_sample),
      .square (square_right)
   );

   // Merge of both lanes into the buffer sum and pair count.
   srlm_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .add_en         (state_ff == S_MERGE),
      .clear          (merge_clear),
      .square_left    (square_left),
      .square_right   (square_right),
      .sum_of_squares (sum_of_squares),
      .sample_count   (sample_count)
   );

   srlm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .quotient (quotient),
      .done     (div_done)
   );

   srlm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .root     (root),
      .done     (sqrt_done)
   );

   assign accept   = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);

   // Unit requests: the sum is cleared as soon as the divider has taken it.
   always_comb begin
      fs_eff           = (full_scale_ff == '0) ? LEVEL_W'(1) : full_scale_ff;
      merge_clear      = (state_ff == S_MEAN);
      div_req.start    = (state_ff == S_MEAN) || (state_ff == S_SCALE);
      div_req.dividend = sum_of_squares;
      div_req.divisor  = DIVISOR_W'({sample_count, 1'b0});
      if (state_ff == S_SCALE) begin
         div_req.dividend = SUM_W'({acc_ff, 8'b0});
         div_req.divisor  = DIVISOR_W'(fs_eff);
      end
      sqrt_start = (state_ff == S_ROOT);
      radicand   = count_zero_ff ? '0 : quotient;
   end

   // Smoothing arithmetic and the mapping against full scale.
   always_comb begin
      diff    = $signed({2'b00, rms_ff, 8'b0}) - $signed({1'b0, acc_ff});
      acc_sum = $signed({(PROD_W - ACC_W - 16)'(0), acc_ff, 16'b0}) + prod_ff
                + $signed(PROD_W'(32768));
      smoothed_round = {1'b0, acc_ff} + (ACC_W + 1)'(128);
      scaled  = (quotient[SUM_W-1:SCALED_W] != '0) ? {SCALED_W{1'b1}}
                                                   : quotient[SCALED_W-1:0];
      if (scaled > BAND_3QUARTER) begin
         band = BAND_HIGH;
      end else if (scaled > BAND_HALF) begin
         band = BAND_HIGH_MID;
      end else if (scaled > BAND_QUARTER) begin
         band = BAND_LOW_MID;
      end else begin
         band = BAND_LOW;
      end
   end

   // Sequencer, configuration registers and the output register.
   always_comb begin
      state_in        = state_ff;
      last_in         = last_ff;
      count_zero_in   = count_zero_ff;
      rms_in          = rms_ff;
      acc_in          = acc_ff;
      prod_in         = prod_ff;
      alpha_in        = alpha_ff;
      full_scale_in   = full_scale_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_rms_in      = rsp_rms_ff;
      rsp_smoothed_in = rsp_smoothed_ff;
      rsp_scaled_in   = rsp_scaled_ff;
      rsp_band_in     = rsp_band_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_SMOOTH_ALPHA: begin
               alpha_in = csr_data[ALPHA_W-1:0];
            end
            CSR_FULL_SCALE_LEVEL: begin
               full_scale_in = csr_data[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in  = req_chan.last_in_buffer;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            state_in = last_ff ? S_MEAN : S_IDLE;
         end
         S_MEAN: begin
            count_zero_in = (sample_count == '0);
            state_in      = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_done) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sqrt_done) begin
               // A full-scale mean gives a root of 32768, which clamps.
               rms_in   = (root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root[LEVEL_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, alpha_ff}) * diff;
            state_in = S_ADD;
         end
         S_ADD: begin
            acc_in   = acc_sum[ACC_W+15:16];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_SCALE_WAIT;
         end
         S_SCALE_WAIT: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_rms_in      = rms_ff;
               rsp_smoothed_in = (smoothed_round[ACC_W:8] > (ACC_W - 7)'(LEVEL_MAX))
                                 ? LEVEL_MAX : smoothed_round[LEVEL_W+7:8];
               rsp_scaled_in   = scaled;
               rsp_band_in     = band;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_ff       <= 1'b0;
         count_zero_ff <= 1'b0;
         acc_ff        <= '0;
         alpha_ff      <= SMOOTH_ALPHA_RESET;
         full_scale_ff <= FULL_SCALE_LEVEL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         count_zero_ff <= count_zero_in;
         acc_ff        <= acc_in;
         alpha_ff      <= alpha_in;
         full_scale_ff <= full_scale_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rms_ff          <= rms_in;
      prod_ff         <= prod_in;
      rsp_rms_ff      <= rsp_rms_in;
      rsp_smoothed_ff <= rsp_smoothed_in;
      rsp_scaled_ff   <= rsp_scaled_in;
      rsp_band_ff     <= rsp_band_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.rms_level      = rsp_rms_ff;
   assign rsp_chan.smoothed_level = rsp_smoothed_ff;
   assign rsp_chan.scaled_level   = rsp_scaled_ff;
   assign rsp_chan.level_band     = rsp_band_ff;
endmodule
